/* hw/rtl/cgs_pkg.sv */
`timescale 1ns / 1ps

package cgs_pkg;

  // Fixed field widths of the streaming words.
  localparam int CODE_W           = 16;
  localparam int IDX_W            = 4;
  localparam int CNT_W            = 5;
  localparam int RULE_ENTRIES_DEF = 16;

  // Values of the func field.
  localparam logic FUNC_RULE = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic has_left;
    logic has_right;
    logic has_mid;
  } flags_t;

  typedef struct packed {
    code_t left;
    code_t right;
    code_t mid;
  } forms_t;

  // One rule entry as written into a cell.
  typedef struct packed {
    code_t  code;
    forms_t forms;
    flags_t flags;
  } rule_t;

  // Result of matching one code against the rule cells seen so far.
  typedef struct packed {
    logic   found;
    flags_t flags;
  } hit_t;

  // Query word that walks down the row of cells: the codes looked up and
  // the matches collected so far. The fourth lookup is for code zero.
  typedef struct packed {
    code_t  held;
    code_t  prev;
    code_t  ch;
    hit_t   held_hit;
    hit_t   prev_hit;
    hit_t   ch_hit;
    hit_t   zero_hit;
    forms_t held_forms;
    forms_t ch_forms;
  } qry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

/* hw/rtl/cgs_if.sv */
`timescale 1ns / 1ps

interface cgs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [cgs_pkg::CODE_W-1:0] char_code;
  logic                       is_last;
  logic [cgs_pkg::IDX_W-1:0]  rule_index;
  logic [cgs_pkg::CODE_W-1:0] rule_char;
  logic [cgs_pkg::CODE_W-1:0] rule_left_glyph;
  logic [cgs_pkg::CODE_W-1:0] rule_right_glyph;
  logic [cgs_pkg::CODE_W-1:0] rule_middle_glyph;
  logic                       rule_has_left;
  logic                       rule_has_right;
  logic                       rule_has_middle;

  modport source (
    output valid, func, char_code, is_last, rule_index, rule_char,
           rule_left_glyph, rule_right_glyph, rule_middle_glyph,
           rule_has_left, rule_has_right, rule_has_middle,
    input  ready
  );

  modport sink (
    input  valid, func, char_code, is_last, rule_index, rule_char,
           rule_left_glyph, rule_right_glyph, rule_middle_glyph,
           rule_has_left, rule_has_right, rule_has_middle,
    output ready
  );
endinterface

interface cgs_out_if;
  logic                       valid;
  logic                       ready;
  logic [cgs_pkg::CODE_W-1:0] glyph_code;
  logic                       last_of_text;

  modport source (
    output valid, glyph_code, last_of_text,
    input  ready
  );

  modport sink (
    input  valid, glyph_code, last_of_text,
    output ready
  );
endinterface

/* hw/rtl/cgs_cell.sv */
`timescale 1ns / 1ps

// One rule entry. The query word passes through a register, picking up this entry's
// flags for every code not yet matched, and its forms for the held and new codes.
module cgs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           active_i,
  input  logic           we_i,
  input  cgs_pkg::rule_t rule_i,
  input  logic           qv_i,
  input  cgs_pkg::qry_t  q_i,
  output logic           qv_o,
  output cgs_pkg::qry_t  q_o
);

  cgs_pkg::code_t  code_q;
  cgs_pkg::forms_t forms_q;
  cgs_pkg::flags_t flags_q;
  cgs_pkg::qry_t   q_d;
  cgs_pkg::qry_t   q_q;
  logic            qv_q;
  logic            m_held;
  logic            m_prev;
  logic            m_ch;
  logic            m_zero;

  always_comb begin
    m_held = active_i && !q_i.held_hit.found && (q_i.held == code_q);
    m_prev = active_i && !q_i.prev_hit.found && (q_i.prev == code_q);
    m_ch   = active_i && !q_i.ch_hit.found   && (q_i.ch == code_q);
    m_zero = active_i && !q_i.zero_hit.found && (code_q == '0);
    q_d = q_i;
    if (m_held) begin
      q_d.held_hit   = '{found: 1'b1, flags: flags_q};
      q_d.held_forms = forms_q;
    end
    if (m_prev) begin
      q_d.prev_hit = '{found: 1'b1, flags: flags_q};
    end
    if (m_ch) begin
      q_d.ch_hit   = '{found: 1'b1, flags: flags_q};
      q_d.ch_forms = forms_q;
    end
    if (m_zero) begin
      q_d.zero_hit = '{found: 1'b1, flags: flags_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      code_q  <= rule_i.code;
      forms_q <= rule_i.forms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      qv_q    <= 1'b0;
    end else begin
      if (we_i) begin
        flags_q <= rule_i.flags;
      end
      qv_q <= qv_i;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign qv_o = qv_q;
  assign q_o  = q_q;

endmodule

/* hw/rtl/contextual_glyph_substitution_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Word
// in_i      in   valid/ready   func, char_code, is_last, rule_* fields
// out_o     out  valid/ready   glyph_code, last_of_text
// cfg       in   cfg_we_i      cfg_wdata_i = rule_count
//
// A rule write lands directly in its cell. A character word sends a query down the row of
// RULE_ENTRIES rule cells, one cell per cycle; the next word is taken only once the query has
// left the last cell and every result word has been delivered. Reset clears the rule flags,
// rule_count and the text context; codes and forms of the rules hold whatever they had until
// written. A stall on the output holds the results in their registers and keeps the input
// closed.
module contextual_glyph_substitution_top #(
  parameter int RULE_ENTRIES = cgs_pkg::RULE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cgs_pkg::CNT_W-1:0]  cfg_wdata_i,
  cgs_in_if.sink                     in_i,
  cgs_out_if.source                  out_o
);

  // Picks the glyph for one character from its own match and the matches
  // of its neighbors. A right form beats a left one; the middle form needs
  // joins on both sides.
  function automatic cgs_pkg::code_t shape(
    input cgs_pkg::code_t  ch,
    input cgs_pkg::hit_t   self,
    input cgs_pkg::forms_t forms,
    input cgs_pkg::hit_t   prev,
    input cgs_pkg::hit_t   next
  );
    cgs_pkg::code_t res;
    logic           jn;
    logic           jp;
    res = ch;
    jn  = self.found && self.flags.has_left && next.found &&
          (next.flags.has_right || next.flags.has_mid);
    jp  = self.found && self.flags.has_right && prev.found &&
          (prev.flags.has_left || prev.flags.has_mid);
    if (jn) begin
      res = forms.left;
    end
    if (jp) begin
      res = forms.right;
    end
    if (self.found && self.flags.has_mid && jn && jp) begin
      res = forms.mid;
    end
    return res;
  endfunction

  cgs_pkg::state_e             state_q, state_d;
  logic [cgs_pkg::CNT_W-1:0]   rule_cnt_q;
  cgs_pkg::code_t              held_q, held_d;
  cgs_pkg::code_t              prev_q, prev_d;
  logic                        held_vld_q, held_vld_d;
  logic                        is_last_q;
  cgs_pkg::code_t              res_q [2];
  cgs_pkg::code_t              res_d [2];
  logic [1:0]                  res_vld_q, res_vld_d;

  logic                        in_acc;
  logic                        inject;
  logic                        rule_wr;
  cgs_pkg::rule_t              rule_w;
  cgs_pkg::qry_t               q_in;
  cgs_pkg::qry_t               q_res;
  logic                        qv_res;

  logic                        qv_chain [RULE_ENTRIES+1];
  cgs_pkg::qry_t               q_chain  [RULE_ENTRIES+1];

  assign in_acc  = in_i.valid && in_i.ready;
  assign inject  = in_acc && (in_i.func == cgs_pkg::FUNC_CHAR);
  assign rule_wr = in_acc && (in_i.func == cgs_pkg::FUNC_RULE);

  assign rule_w = '{
    code:  in_i.rule_char,
    forms: '{left: in_i.rule_left_glyph, right: in_i.rule_right_glyph,
             mid: in_i.rule_middle_glyph},
    flags: '{has_left: in_i.rule_has_left, has_right: in_i.rule_has_right,
             has_mid: in_i.rule_has_middle}
  };

  // The query carries the held character, the one before it and the new
  // one; nothing has matched when it enters the first cell.
  always_comb begin
    q_in      = '0;
    q_in.held = held_q;
    q_in.prev = prev_q;
    q_in.ch   = in_i.char_code;
  end

  assign qv_chain[0] = inject;
  assign q_chain[0]  = q_in;

  // The row of rule cells. Only cells below rule_count take part in
  // matching, so the first matching cell in the row is the lowest index.
  for (genvar i = 0; i < RULE_ENTRIES; i++) begin : g_cell
    logic active;
    logic we;
    assign active = (i < int'(rule_cnt_q));
    assign we     = rule_wr && (int'(in_i.rule_index) == i);

    cgs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active),
      .we_i     (we),
      .rule_i   (rule_w),
      .qv_i     (qv_chain[i]),
      .q_i      (q_chain[i]),
      .qv_o     (qv_chain[i+1]),
      .q_o      (q_chain[i+1])
    );
  end

  assign qv_res = qv_chain[RULE_ENTRIES];
  assign q_res  = q_chain[RULE_ENTRIES];

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    prev_d     = prev_q;
    held_vld_d = held_vld_q;
    res_d[0]   = res_q[0];
    res_d[1]   = res_q[1];
    res_vld_d  = res_vld_q;
    in_i.ready = 1'b0;

    unique case (state_q)
      cgs_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (inject) begin
          state_d = cgs_pkg::ST_SCAN;
        end
      end
      cgs_pkg::ST_SCAN: begin
        if (qv_res) begin
          // The held character now knows its right neighbor; the new one
          // is shaped at once only when it ends the text, with code zero
          // standing in after it.
          res_d[0] = shape(q_res.held, q_res.held_hit, q_res.held_forms,
                           q_res.prev_hit, q_res.ch_hit);
          res_d[1] = shape(q_res.ch, q_res.ch_hit, q_res.ch_forms,
                           held_vld_q ? q_res.held_hit : q_res.prev_hit,
                           q_res.zero_hit);
          res_vld_d = {is_last_q, held_vld_q};
          if (is_last_q) begin
            held_d     = '0;
            prev_d     = '0;
            held_vld_d = 1'b0;
          end else begin
            if (held_vld_q) begin
              prev_d = held_q;
            end
            held_d     = q_res.ch;
            held_vld_d = 1'b1;
          end
          state_d = (is_last_q || held_vld_q) ? cgs_pkg::ST_EMIT : cgs_pkg::ST_IDLE;
        end
      end
      cgs_pkg::ST_EMIT: begin
        if (out_o.ready) begin
          if (res_vld_q[0]) begin
            res_vld_d[0] = 1'b0;
            if (!res_vld_q[1]) begin
              state_d = cgs_pkg::ST_IDLE;
            end
          end else begin
            res_vld_d[1] = 1'b0;
            state_d      = cgs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = cgs_pkg::ST_IDLE;
      end
    endcase
  end

  // The held character's word goes out first, then the text's last one.
  assign out_o.valid        = (state_q == cgs_pkg::ST_EMIT);
  assign out_o.glyph_code   = res_vld_q[0] ? res_q[0] : res_q[1];
  assign out_o.last_of_text = !res_vld_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cgs_pkg::ST_IDLE;
      rule_cnt_q <= '0;
      held_q     <= '0;
      prev_q     <= '0;
      held_vld_q <= 1'b0;
      res_vld_q  <= '0;
    end else begin
      state_q    <= state_d;
      held_q     <= held_d;
      prev_q     <= prev_d;
      held_vld_q <= held_vld_d;
      res_vld_q  <= res_vld_d;
      if (cfg_we_i) begin
        rule_cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
    if (inject) begin
      is_last_q <= in_i.is_last;
    end
  end

endmodule
